// ----- src/iso_dec_pkg.sv -----
// iso 6937 decoder package: payload types, register codes and lookup functions
// no dependencies
`timescale 1ns / 1ps
package iso_dec_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       field_end;
    } in_item_t;

    typedef struct packed {
        logic        has_char;
        logic [15:0] code_point;
        logic        field_end_res;
    } out_item_t;

    typedef enum logic [1:0] {
        TABLE_ISO    = 2'd0,
        TABLE_PASS   = 2'd1,
        TABLE_NONE_A = 2'd2,
        TABLE_NONE_B = 2'd3
    } code_table_t;

    localparam logic [0:0] REG_CODE_TABLE = 1'b0;
    localparam logic [0:0] REG_WIDE_MODE  = 1'b1;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h8A;
    localparam logic [15:0] CP_NEWLINE    = 16'd10;

    function automatic logic is_diacritic(input logic [7:0] b);
        return b >= 8'hC1 && b <= 8'hCF && b != 8'hC9 && b != 8'hCC;
    endfunction

    function automatic logic [15:0] upper_map(input logic [6:0] i);
        logic [15:0] r;
        case (i)
            7'd1: r = 16'hA1;   7'd2: r = 16'hA2;   7'd3: r = 16'hA3;   7'd4: r = 16'h24;
            7'd5: r = 16'hA5;   7'd6: r = 16'h23;   7'd7: r = 16'hA7;   7'd8: r = 16'hA4;
            7'd9: r = 16'h2018; 7'd10: r = 16'h201C; 7'd11: r = 16'hAB; 7'd12: r = 16'h2190;
            7'd13: r = 16'h2191; 7'd14: r = 16'h2192; 7'd15: r = 16'h2193; 7'd16: r = 16'hB0;
            7'd17: r = 16'hB1;  7'd18: r = 16'hB2;  7'd19: r = 16'hB3;  7'd20: r = 16'hD7;
            7'd21: r = 16'hB5;  7'd22: r = 16'hB6;  7'd23: r = 16'hB7;  7'd24: r = 16'hF7;
            7'd25: r = 16'h2019; 7'd26: r = 16'h201D; 7'd27: r = 16'hBB; 7'd28: r = 16'hBC;
            7'd29: r = 16'hBD;  7'd31: r = 16'hBF;  7'd32: r = 16'h3F;  7'd41: r = 16'h3F;
            7'd48: r = 16'h2015; 7'd49: r = 16'hB9; 7'd50: r = 16'hAE;  7'd51: r = 16'hA9;
            7'd52: r = 16'h2122; 7'd53: r = 16'h266A; 7'd58: r = 16'h3F; 7'd59: r = 16'h3F;
            7'd60: r = 16'h215B; 7'd61: r = 16'h215C; 7'd62: r = 16'h215D; 7'd63: r = 16'h215E;
            7'd64: r = 16'h2126; 7'd65: r = 16'hC6; 7'd66: r = 16'hD0;  7'd68: r = 16'h126;
            7'd69: r = 16'h3F;  7'd70: r = 16'h132; 7'd71: r = 16'h13F; 7'd72: r = 16'h141;
            7'd73: r = 16'hD8;  7'd74: r = 16'h152; 7'd75: r = 16'hBA;  7'd76: r = 16'hDE;
            7'd77: r = 16'h166; 7'd78: r = 16'h14A; 7'd79: r = 16'h149; 7'd80: r = 16'h138;
            7'd81: r = 16'hE6;  7'd82: r = 16'h111; 7'd83: r = 16'hF0;  7'd84: r = 16'h127;
            7'd85: r = 16'h131; 7'd86: r = 16'h133; 7'd87: r = 16'h140; 7'd88: r = 16'h142;
            7'd89: r = 16'hF8;  7'd90: r = 16'h153; 7'd91: r = 16'hDF;  7'd92: r = 16'hFE;
            7'd93: r = 16'h167;
            default: r = 16'h0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] single_map(input logic [7:0] b);
        logic [15:0] r;
        if (b >= 8'hA0)
            r = upper_map(7'(b - 8'hA0));
        else if (b == 8'h24)
            r = 16'hA4;
        else if (b == 8'h7F)
            r = 16'h0;
        else
            r = {8'h00, b};
        return r;
    endfunction

    function automatic logic [15:0] find_combo(input logic [3:0] m, input logic [7:0] c);
        logic [15:0] r;
        r = 16'h0;
        case ({m, c})
            {4'd1, "A"}: r = 16'hC0;  {4'd1, "E"}: r = 16'hC8;  {4'd1, "I"}: r = 16'hCC;
            {4'd1, "O"}: r = 16'hD2;  {4'd1, "U"}: r = 16'hD9;  {4'd1, "a"}: r = 16'hE0;
            {4'd1, "e"}: r = 16'hE8;  {4'd1, "i"}: r = 16'hEC;  {4'd1, "o"}: r = 16'hF2;
            {4'd1, "u"}: r = 16'hF9;
            {4'd2, "A"}: r = 16'hC1;  {4'd2, "C"}: r = 16'h106; {4'd2, "E"}: r = 16'hC9;
            {4'd2, "I"}: r = 16'hCD;  {4'd2, "L"}: r = 16'h139; {4'd2, "N"}: r = 16'h143;
            {4'd2, "O"}: r = 16'hD3;  {4'd2, "R"}: r = 16'h154; {4'd2, "S"}: r = 16'h15A;
            {4'd2, "U"}: r = 16'hDA;  {4'd2, "Y"}: r = 16'hDD;  {4'd2, "Z"}: r = 16'h179;
            {4'd2, "a"}: r = 16'hE1;  {4'd2, "c"}: r = 16'h107; {4'd2, "e"}: r = 16'hE9;
            {4'd2, "g"}: r = 16'h123; {4'd2, "i"}: r = 16'hED;  {4'd2, "l"}: r = 16'h13A;
            {4'd2, "n"}: r = 16'h144; {4'd2, "o"}: r = 16'hF3;  {4'd2, "r"}: r = 16'h155;
            {4'd2, "s"}: r = 16'h15B; {4'd2, "u"}: r = 16'hFA;  {4'd2, "y"}: r = 16'hFD;
            {4'd2, "z"}: r = 16'h17A;
            {4'd3, "A"}: r = 16'hC2;  {4'd3, "C"}: r = 16'h108; {4'd3, "E"}: r = 16'hCA;
            {4'd3, "G"}: r = 16'h11C; {4'd3, "H"}: r = 16'h124; {4'd3, "I"}: r = 16'hCE;
            {4'd3, "J"}: r = 16'h134; {4'd3, "O"}: r = 16'hD4;  {4'd3, "S"}: r = 16'h15C;
            {4'd3, "U"}: r = 16'hDB;  {4'd3, "W"}: r = 16'h174; {4'd3, "Y"}: r = 16'h176;
            {4'd3, "a"}: r = 16'hE2;  {4'd3, "c"}: r = 16'h109; {4'd3, "e"}: r = 16'hEA;
            {4'd3, "g"}: r = 16'h11D; {4'd3, "h"}: r = 16'h125; {4'd3, "j"}: r = 16'h135;
            {4'd3, "o"}: r = 16'hF4;  {4'd3, "s"}: r = 16'h15D; {4'd3, "u"}: r = 16'hFB;
            {4'd3, "w"}: r = 16'h175; {4'd3, "y"}: r = 16'h177; {4'd3, "i"}: r = 16'hEE;
            {4'd4, "A"}: r = 16'hC3;  {4'd4, "I"}: r = 16'h128; {4'd4, "N"}: r = 16'hD1;
            {4'd4, "O"}: r = 16'hD5;  {4'd4, "U"}: r = 16'h168; {4'd4, "a"}: r = 16'hE3;
            {4'd4, "i"}: r = 16'h129; {4'd4, "n"}: r = 16'hF1;  {4'd4, "o"}: r = 16'hF5;
            {4'd4, "u"}: r = 16'h169;
            {4'd5, "A"}: r = 16'h100; {4'd5, "E"}: r = 16'h112; {4'd5, "I"}: r = 16'h12A;
            {4'd5, "O"}: r = 16'h14C; {4'd5, "U"}: r = 16'h16A; {4'd5, "a"}: r = 16'h101;
            {4'd5, "e"}: r = 16'h113; {4'd5, "i"}: r = 16'h12B; {4'd5, "o"}: r = 16'h14D;
            {4'd5, "u"}: r = 16'h16B;
            {4'd6, "A"}: r = 16'h102; {4'd6, "G"}: r = 16'h11E; {4'd6, "U"}: r = 16'h16C;
            {4'd6, "a"}: r = 16'h103; {4'd6, "g"}: r = 16'h11F; {4'd6, "u"}: r = 16'h16D;
            {4'd7, "C"}: r = 16'h10A; {4'd7, "E"}: r = 16'h116; {4'd7, "G"}: r = 16'h120;
            {4'd7, "I"}: r = 16'h130; {4'd7, "Z"}: r = 16'h17B; {4'd7, "c"}: r = 16'h10B;
            {4'd7, "e"}: r = 16'h117; {4'd7, "g"}: r = 16'h121; {4'd7, "i"}: r = 16'h131;
            {4'd7, "z"}: r = 16'h17C;
            {4'd8, "A"}: r = 16'hC4;  {4'd8, "E"}: r = 16'hCB;  {4'd8, "I"}: r = 16'hCF;
            {4'd8, "O"}: r = 16'hD6;  {4'd8, "U"}: r = 16'hDC;  {4'd8, "Y"}: r = 16'h178;
            {4'd8, "a"}: r = 16'hE4;  {4'd8, "e"}: r = 16'hEB;  {4'd8, "i"}: r = 16'hEF;
            {4'd8, "o"}: r = 16'hF6;  {4'd8, "u"}: r = 16'hFC;  {4'd8, "y"}: r = 16'hFF;
            {4'd10, "A"}: r = 16'hC5; {4'd10, "U"}: r = 16'h16E; {4'd10, "a"}: r = 16'hE5;
            {4'd10, "u"}: r = 16'h16F;
            {4'd11, "C"}: r = 16'hC7; {4'd11, "G"}: r = 16'h122; {4'd11, "K"}: r = 16'h136;
            {4'd11, "L"}: r = 16'h13B; {4'd11, "N"}: r = 16'h145; {4'd11, "R"}: r = 16'h156;
            {4'd11, "S"}: r = 16'h15E; {4'd11, "T"}: r = 16'h162; {4'd11, "c"}: r = 16'hE7;
            {4'd11, "k"}: r = 16'h137; {4'd11, "l"}: r = 16'h13C; {4'd11, "n"}: r = 16'h146;
            {4'd11, "r"}: r = 16'h157; {4'd11, "s"}: r = 16'h15F; {4'd11, "t"}: r = 16'h163;
            {4'd13, "O"}: r = 16'h150; {4'd13, "U"}: r = 16'h170; {4'd13, "o"}: r = 16'h151;
            {4'd13, "u"}: r = 16'h171;
            {4'd14, "A"}: r = 16'h104; {4'd14, "E"}: r = 16'h118; {4'd14, "I"}: r = 16'h12E;
            {4'd14, "U"}: r = 16'h172; {4'd14, "a"}: r = 16'h105; {4'd14, "e"}: r = 16'h119;
            {4'd14, "i"}: r = 16'h12F; {4'd14, "u"}: r = 16'h173;
            {4'd15, "C"}: r = 16'h10C; {4'd15, "D"}: r = 16'h10E; {4'd15, "E"}: r = 16'h11A;
            {4'd15, "L"}: r = 16'h13D; {4'd15, "N"}: r = 16'h147; {4'd15, "R"}: r = 16'h158;
            {4'd15, "S"}: r = 16'h160; {4'd15, "T"}: r = 16'h164; {4'd15, "Z"}: r = 16'h17D;
            {4'd15, "c"}: r = 16'h10D; {4'd15, "d"}: r = 16'h10F; {4'd15, "e"}: r = 16'h11B;
            {4'd15, "l"}: r = 16'h13E; {4'd15, "n"}: r = 16'h148; {4'd15, "r"}: r = 16'h159;
            {4'd15, "s"}: r = 16'h161; {4'd15, "t"}: r = 16'h165; {4'd15, "z"}: r = 16'h17E;
            default: r = 16'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/iso_dec_if.sv -----
// valid/ready channel interfaces for input and result items
// depends on iso_dec_pkg
`timescale 1ns / 1ps
interface iso_dec_in_if;
    logic                 valid;
    logic                 ready;
    iso_dec_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface iso_dec_out_if;
    logic                  valid;
    logic                  ready;
    iso_dec_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/iso_dec_cfg.sv -----
// apb configuration registers: code table and wide mode
// depends on iso_dec_pkg
`timescale 1ns / 1ps
module iso_dec_cfg
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output iso_dec_pkg::code_table_t code_table,
    output logic                     wide_char_mode
);
    import iso_dec_pkg::*;

    code_table_t table_reg, table_next;
    logic        wide_reg, wide_next;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb
    begin
        table_next = table_reg;
        wide_next  = wide_reg;
        if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_CODE_TABLE)
                table_next = code_table_t'(pwdata[1:0]);
            else
                wide_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= TABLE_ISO;
            wide_reg  <= 1'b0;
        end
        else
        begin
            table_reg <= table_next;
            wide_reg  <= wide_next;
        end
    end

    always_comb
    begin
        prdata = 32'h0;
        if (paddr[2] == REG_WIDE_MODE)
            prdata[0] = wide_reg;
        else
            prdata[1:0] = table_reg;
    end

    assign code_table     = table_reg;
    assign wide_char_mode = wide_reg;
endmodule

// ----- src/iso_dec_core.sv -----
// decode stage: pending state, lookup and result register
// depends on iso_dec_pkg and iso_dec_if
`timescale 1ns / 1ps
module iso_dec_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  iso_dec_pkg::code_table_t code_table,
    input  logic                     wide_char_mode,
    iso_dec_in_if.sink               in_ch,
    iso_dec_out_if.source            out_ch,
    output logic                     mark_pending
);
    import iso_dec_pkg::*;

    logic        out_valid_reg;
    out_item_t   out_reg, out_next;
    logic [3:0]  mark_reg, mark_next;
    logic        skip_reg, skip_next;
    logic        take;
    logic [7:0]  b;
    logic        is_char;
    logic [15:0] cp, combo;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;
    assign b = in_ch.data.byte_value;
    assign is_char = (b >= 8'h20 && b <= 8'h7F) || b >= 8'hA1;
    assign combo = (mark_reg != 4'd0) ? find_combo(mark_reg, b) : 16'h0;

    always_comb
    begin
        cp        = 16'h0;
        mark_next = 4'd0;
        skip_next = 1'b0;
        if (skip_reg)
            skip_next = 1'b0;
        else if (!is_char)
        begin
            if (b == BYTE_NEWLINE)
                cp = CP_NEWLINE;
        end
        else if (wide_char_mode)
            skip_next = 1'b1;
        else
        begin
            case (code_table)
                TABLE_ISO:
                begin
                    cp = combo;
                    if (combo == 16'h0)
                    begin
                        if (is_diacritic(b))
                            mark_next = b[3:0];
                        else
                            cp = single_map(b);
                    end
                end
                TABLE_PASS: cp = {8'h00, b};
                default: cp = 16'h0;
            endcase
        end
        if (in_ch.data.field_end)
        begin
            mark_next = 4'd0;
            skip_next = 1'b0;
        end
        out_next.has_char      = cp != 16'h0;
        out_next.code_point    = cp;
        out_next.field_end_res = in_ch.data.field_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mark_reg      <= 4'd0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                out_valid_reg <= in_ch.valid;
            if (take)
            begin
                mark_reg <= mark_next;
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.data   = out_reg;
    assign mark_pending  = mark_reg != 4'd0;
endmodule

// ----- src/iso6937_subtitle_text_decoder_unit.sv -----
// top level of the iso 6937 subtitle text decoder
// depends on iso_dec_pkg, iso_dec_if, iso_dec_cfg, iso_dec_core
//
// channel   dir   handshake      payload
// in_ch     in    valid/ready    byte_value, field_end
// out_ch    out   valid/ready    has_char, code_point, field_end_res
// apb       in    psel/penable   code_table @0x0, wide_char_mode @0x4
//
// one item per cycle while the result is not stalled; each item gives one result in the cycle after acceptance
// latency is set by the single result register after the table lookup
// reset clears pending diacritic, wide skip, registers and result valid
// a stalled result holds; a new item enters in the same cycle the result leaves
`timescale 1ns / 1ps
module iso6937_subtitle_text_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    iso_dec_in_if.sink  in_ch,
    iso_dec_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iso_dec_pkg::*;

    code_table_t code_table;
    logic        wide_char_mode;
    logic        mark_pending;

    iso_dec_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .code_table     (code_table),
        .wide_char_mode (wide_char_mode)
    );

    iso_dec_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .code_table     (code_table),
        .wide_char_mode (wide_char_mode),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mark_pending   (mark_pending)
    );

    a_fe_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.data.field_end |=> !mark_pending)
        else $error("diacritic survives field end");

    a_cp_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.has_char == (out_ch.data.code_point != 16'h0)))
        else $error("has_char disagrees with code point");

    a_wide_nomark: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && wide_char_mode |=> !mark_pending)
        else $error("diacritic held in wide mode");

    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.code_point == CP_NEWLINE |-> out_ch.data.has_char)
        else $error("newline without char flag");
endmodule

// ----- test/iso6937_subtitle_text_decoder_unit_tb.sv -----
// testbench for the iso 6937 subtitle text decoder: directed and random byte streams
// with apb register phases, checked against an in-bench decoder model
// depends on iso_dec_pkg, iso_dec_if and the decoder rtl
`timescale 1ns / 1ps
module iso6937_subtitle_text_decoder_unit_tb;
    import iso_dec_pkg::*;

    class decode_scoreboard;
        code_table_t table_sel;
        bit          wide_mode;
        logic [3:0]  pending_mark;
        bit          skip_next;
        out_item_t   expected_chars[$];
        int          mismatches;
        int          chars_seen;
        int          results_seen;

        function new();
            table_sel    = TABLE_ISO;
            wide_mode    = 1'b0;
            pending_mark = 4'd0;
            skip_next    = 1'b0;
            mismatches   = 0;
            chars_seen   = 0;
            results_seen = 0;
        endfunction

        function logic [15:0] combine(logic [3:0] m, logic [7:0] c);
            logic [7:0] u;
            logic       lo;
            logic [15:0] r;
            u  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            lo = (c >= "a" && c <= "z");
            r  = 16'h0;
            case (m)
                4'd1: case (u)
                    "A": r = lo ? 16'hE0 : 16'hC0; "E": r = lo ? 16'hE8 : 16'hC8;
                    "I": r = lo ? 16'hEC : 16'hCC; "O": r = lo ? 16'hF2 : 16'hD2;
                    "U": r = lo ? 16'hF9 : 16'hD9;
                    default: r = 16'h0;
                endcase
                4'd2: case (c)
                    "A": r = 16'hC1; "C": r = 16'h106; "E": r = 16'hC9; "I": r = 16'hCD;
                    "L": r = 16'h139; "N": r = 16'h143; "O": r = 16'hD3; "R": r = 16'h154;
                    "S": r = 16'h15A; "U": r = 16'hDA; "Y": r = 16'hDD; "Z": r = 16'h179;
                    "a": r = 16'hE1; "c": r = 16'h107; "e": r = 16'hE9; "g": r = 16'h123;
                    "i": r = 16'hED; "l": r = 16'h13A; "n": r = 16'h144; "o": r = 16'hF3;
                    "r": r = 16'h155; "s": r = 16'h15B; "u": r = 16'hFA; "y": r = 16'hFD;
                    "z": r = 16'h17A;
                    default: r = 16'h0;
                endcase
                4'd3: case (c)
                    "A": r = 16'hC2; "C": r = 16'h108; "E": r = 16'hCA; "G": r = 16'h11C;
                    "H": r = 16'h124; "I": r = 16'hCE; "J": r = 16'h134; "O": r = 16'hD4;
                    "S": r = 16'h15C; "U": r = 16'hDB; "W": r = 16'h174; "Y": r = 16'h176;
                    "a": r = 16'hE2; "c": r = 16'h109; "e": r = 16'hEA; "g": r = 16'h11D;
                    "h": r = 16'h125; "j": r = 16'h135; "o": r = 16'hF4; "s": r = 16'h15D;
                    "u": r = 16'hFB; "w": r = 16'h175; "y": r = 16'h177; "i": r = 16'hEE;
                    default: r = 16'h0;
                endcase
                4'd4: case (c)
                    "A": r = 16'hC3; "I": r = 16'h128; "N": r = 16'hD1; "O": r = 16'hD5;
                    "U": r = 16'h168; "a": r = 16'hE3; "i": r = 16'h129; "n": r = 16'hF1;
                    "o": r = 16'hF5; "u": r = 16'h169;
                    default: r = 16'h0;
                endcase
                4'd5: case (u)
                    "A": r = lo ? 16'h101 : 16'h100; "E": r = lo ? 16'h113 : 16'h112;
                    "I": r = lo ? 16'h12B : 16'h12A; "O": r = lo ? 16'h14D : 16'h14C;
                    "U": r = lo ? 16'h16B : 16'h16A;
                    default: r = 16'h0;
                endcase
                4'd6: case (u)
                    "A": r = lo ? 16'h103 : 16'h102; "G": r = lo ? 16'h11F : 16'h11E;
                    "U": r = lo ? 16'h16D : 16'h16C;
                    default: r = 16'h0;
                endcase
                4'd7: case (u)
                    "C": r = lo ? 16'h10B : 16'h10A; "E": r = lo ? 16'h117 : 16'h116;
                    "G": r = lo ? 16'h121 : 16'h120; "I": r = lo ? 16'h131 : 16'h130;
                    "Z": r = lo ? 16'h17C : 16'h17B;
                    default: r = 16'h0;
                endcase
                4'd8: case (c)
                    "A": r = 16'hC4; "E": r = 16'hCB; "I": r = 16'hCF; "O": r = 16'hD6;
                    "U": r = 16'hDC; "Y": r = 16'h178; "a": r = 16'hE4; "e": r = 16'hEB;
                    "i": r = 16'hEF; "o": r = 16'hF6; "u": r = 16'hFC; "y": r = 16'hFF;
                    default: r = 16'h0;
                endcase
                4'd10: case (c)
                    "A": r = 16'hC5; "U": r = 16'h16E; "a": r = 16'hE5; "u": r = 16'h16F;
                    default: r = 16'h0;
                endcase
                4'd11: case (c)
                    "C": r = 16'hC7; "G": r = 16'h122; "K": r = 16'h136; "L": r = 16'h13B;
                    "N": r = 16'h145; "R": r = 16'h156; "S": r = 16'h15E; "T": r = 16'h162;
                    "c": r = 16'hE7; "k": r = 16'h137; "l": r = 16'h13C; "n": r = 16'h146;
                    "r": r = 16'h157; "s": r = 16'h15F; "t": r = 16'h163;
                    default: r = 16'h0;
                endcase
                4'd13: case (u)
                    "O": r = lo ? 16'h151 : 16'h150; "U": r = lo ? 16'h171 : 16'h170;
                    default: r = 16'h0;
                endcase
                4'd14: case (u)
                    "A": r = lo ? 16'h105 : 16'h104; "E": r = lo ? 16'h119 : 16'h118;
                    "I": r = lo ? 16'h12F : 16'h12E; "U": r = lo ? 16'h173 : 16'h172;
                    default: r = 16'h0;
                endcase
                4'd15: case (c)
                    "C": r = 16'h10C; "D": r = 16'h10E; "E": r = 16'h11A; "L": r = 16'h13D;
                    "N": r = 16'h147; "R": r = 16'h158; "S": r = 16'h160; "T": r = 16'h164;
                    "Z": r = 16'h17D; "c": r = 16'h10D; "d": r = 16'h10F; "e": r = 16'h11B;
                    "l": r = 16'h13E; "n": r = 16'h148; "r": r = 16'h159; "s": r = 16'h161;
                    "t": r = 16'h165; "z": r = 16'h17E;
                    default: r = 16'h0;
                endcase
                default: r = 16'h0;
            endcase
            return r;
        endfunction

        function logic [15:0] upper_char(logic [7:0] b);
            logic [15:0] r;
            case (b)
                8'hA1: r = 16'hA1;   8'hA2: r = 16'hA2;   8'hA3: r = 16'hA3;   8'hA4: r = 16'h24;
                8'hA5: r = 16'hA5;   8'hA6: r = 16'h23;   8'hA7: r = 16'hA7;   8'hA8: r = 16'hA4;
                8'hA9: r = 16'h2018; 8'hAA: r = 16'h201C; 8'hAB: r = 16'hAB;   8'hAC: r = 16'h2190;
                8'hAD: r = 16'h2191; 8'hAE: r = 16'h2192; 8'hAF: r = 16'h2193; 8'hB0: r = 16'hB0;
                8'hB1: r = 16'hB1;   8'hB2: r = 16'hB2;   8'hB3: r = 16'hB3;   8'hB4: r = 16'hD7;
                8'hB5: r = 16'hB5;   8'hB6: r = 16'hB6;   8'hB7: r = 16'hB7;   8'hB8: r = 16'hF7;
                8'hB9: r = 16'h2019; 8'hBA: r = 16'h201D; 8'hBB: r = 16'hBB;   8'hBC: r = 16'hBC;
                8'hBD: r = 16'hBD;   8'hBF: r = 16'hBF;   8'hC0: r = 16'h3F;   8'hC9: r = 16'h3F;
                8'hD0: r = 16'h2015; 8'hD1: r = 16'hB9;   8'hD2: r = 16'hAE;   8'hD3: r = 16'hA9;
                8'hD4: r = 16'h2122; 8'hD5: r = 16'h266A; 8'hDA: r = 16'h3F;   8'hDB: r = 16'h3F;
                8'hDC: r = 16'h215B; 8'hDD: r = 16'h215C; 8'hDE: r = 16'h215D; 8'hDF: r = 16'h215E;
                8'hE0: r = 16'h2126; 8'hE1: r = 16'hC6;   8'hE2: r = 16'hD0;   8'hE4: r = 16'h126;
                8'hE5: r = 16'h3F;   8'hE6: r = 16'h132;  8'hE7: r = 16'h13F;  8'hE8: r = 16'h141;
                8'hE9: r = 16'hD8;   8'hEA: r = 16'h152;  8'hEB: r = 16'hBA;   8'hEC: r = 16'hDE;
                8'hED: r = 16'h166;  8'hEE: r = 16'h14A;  8'hEF: r = 16'h149;  8'hF0: r = 16'h138;
                8'hF1: r = 16'hE6;   8'hF2: r = 16'h111;  8'hF3: r = 16'hF0;   8'hF4: r = 16'h127;
                8'hF5: r = 16'h131;  8'hF6: r = 16'h133;  8'hF7: r = 16'h140;  8'hF8: r = 16'h142;
                8'hF9: r = 16'hF8;   8'hFA: r = 16'h153;  8'hFB: r = 16'hDF;   8'hFC: r = 16'hFE;
                8'hFD: r = 16'h167;
                default: r = 16'h0;
            endcase
            return r;
        endfunction

        function void note_byte(in_item_t it);
            logic [7:0]  b;
            logic [3:0]  m;
            logic [15:0] cp;
            bit          printable;
            out_item_t   e;
            b = it.byte_value;
            m = pending_mark;
            cp = 16'h0;
            printable = (b >= 8'h20 && b <= 8'h7F) || b >= 8'hA1;
            pending_mark = 4'd0;
            if (skip_next)
                skip_next = 1'b0;
            else if (!printable)
            begin
                if (b == BYTE_NEWLINE)
                    cp = CP_NEWLINE;
            end
            else if (wide_mode)
                skip_next = 1'b1;
            else if (table_sel == TABLE_ISO)
            begin
                if (m != 4'd0)
                    cp = combine(m, b);
                if (cp == 16'h0)
                begin
                    if (b >= 8'hC1 && b <= 8'hCF && b != 8'hC9 && b != 8'hCC)
                        pending_mark = b[3:0];
                    else if (b >= 8'hA0)
                        cp = upper_char(b);
                    else if (b == 8'h24)
                        cp = 16'hA4;
                    else if (b != 8'h7F)
                        cp = {8'h00, b};
                end
            end
            else if (table_sel == TABLE_PASS)
                cp = {8'h00, b};
            if (it.field_end)
            begin
                pending_mark = 4'd0;
                skip_next = 1'b0;
            end
            e.has_char = (cp != 16'h0);
            e.code_point = cp;
            e.field_end_res = it.field_end;
            expected_chars.insert(expected_chars.size(), e);
        endfunction

        function void check_char(out_item_t got);
            out_item_t e;
            results_seen++;
            if (got.has_char)
                chars_seen++;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = expected_chars.pop_front();
            if (got.has_char !== e.has_char || got.code_point !== e.code_point
                || got.field_end_res !== e.field_end_res)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char %b cp %h end %b, got %b %h %b",
                             e.has_char, e.code_point, e.field_end_res,
                             got.has_char, got.code_point, got.field_end_res);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          cycle_count;
    int          hold_off;
    int          bytes_sent;

    iso_dec_in_if  in_ch();
    iso_dec_out_if out_ch();
    decode_scoreboard board;

    iso6937_subtitle_text_decoder_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_char(out_ch.data);

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else if (!out_ch.ready || out_ch.valid)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 1) == 0)
                    gap = 0;
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CODE_TABLE)
            board.table_sel = code_table_t'(value[1:0]);
        else
            board.wide_mode = value[0];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fe, input bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 14) : 0;
        if (paced && $urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{byte_value: b, field_end: fe};
        do @(posedge clk); while (!in_ch.ready);
        board.note_byte(in_ch.data);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.expected_chars.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_field(input int n, input bit paced);
        logic [7:0] b;
        int k;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: b = 8'hC0 | 8'($urandom_range(1, 15));
                3, 4, 5: b = 8'($urandom_range(8'h41, 8'h5A) | ($urandom_range(0, 1) << 5));
                6: b = BYTE_NEWLINE;
                7: b = 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(8'h20, 8'hFF));
            endcase
            send_byte(b, (k == n - 1) || ($urandom_range(0, 40) == 0), paced);
        end
    endtask

    initial
    begin
        logic [7:0] directed[$];
        int ph;
        board        = new();
        cycle_count  = 0;
        hold_off     = 0;
        bytes_sent   = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // diacritic merges, dropped diacritics, 0xc9/0xcc, newline, extremes
        directed = '{8'hC1, "a", 8'hCF, "z", 8'hC2, "q", 8'hC8, 8'hC3, "n", 8'hC9, 8'hCC,
                     8'h8A, 8'h00, 8'h20, 8'h7F, 8'hA0, 8'hFF, 8'h24, 8'hCA, 8'h8A, 8'hCD};
        foreach (directed[i])
            send_byte(directed[i], i == directed.size() - 1, 1'b0);
        send_byte("O", 1'b1, 1'b0);
        drain();

        reg_write(REG_CODE_TABLE, 32'(TABLE_PASS));
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h8A, 1'b1, 1'b0);
        drain();
        reg_write(REG_WIDE_MODE, 32'd1);
        send_byte("A", 1'b1, 1'b0);
        send_byte(8'h8A, 1'b0, 1'b0);
        send_byte("B", 1'b0, 1'b0);
        send_byte(8'h8A, 1'b1, 1'b0);
        drain();
        reg_write(REG_WIDE_MODE, 32'd0);
        reg_write(REG_CODE_TABLE, 32'(TABLE_ISO));
        // diacritic left pending across a table change
        send_byte(8'hC2, 1'b0, 1'b0);
        drain();
        reg_write(REG_CODE_TABLE, 32'(TABLE_NONE_B));
        send_byte("a", 1'b1, 1'b0);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            reg_write(REG_CODE_TABLE, 32'((ph < 4) ? TABLE_ISO : code_table_t'(ph % 4)));
            reg_write(REG_WIDE_MODE, (ph == 3 || ph == 6) ? 32'd1 : 32'd0);
            if (ph == 1)
            begin
                hold_off = 300;
                send_field(60, 1'b0);
            end
            while (bytes_sent < 30 + (ph + 1) * 230)
                send_field($urandom_range(1, 30), ph != 2);
            drain();
        end
        repeat (10) @(negedge clk);
        $display("decoded %0d bytes into %0d results, %0d characters, over all tables and modes",
                 bytes_sent, board.results_seen, board.chars_seen);
        if (board.mismatches == 0 && board.expected_chars.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
